[rtl/assert_macros.svh]
// Assertion macros for the blend weight core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

[rtl/tpb_pkg.sv]
`default_nettype none
package tpb_pkg;

  localparam int NLANES = 3;
  localparam int LANE_LAT = 3;  // register stages in one power lane
  localparam int W_ONE = 65536;
  localparam int W_THIRD = 21845;

  localparam logic [0:0] REG_SHARPNESS = 1'd0;
  localparam logic [0:0] REG_NORMALIZE = 1'd1;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } in_t;

  typedef struct packed {
    logic [16:0] weight_x;
    logic [16:0] weight_y;
    logic [16:0] weight_z;
  } out_t;

  // log2(1 + k/16) in Q16
  function automatic logic [16:0] log_tab(input logic [4:0] k);
    case (k)
      5'd0: log_tab = 17'd0;      5'd1: log_tab = 17'd5732;
      5'd2: log_tab = 17'd11136;  5'd3: log_tab = 17'd16248;
      5'd4: log_tab = 17'd21098;  5'd5: log_tab = 17'd25711;
      5'd6: log_tab = 17'd30109;  5'd7: log_tab = 17'd34312;
      5'd8: log_tab = 17'd38336;  5'd9: log_tab = 17'd42196;
      5'd10: log_tab = 17'd45904; 5'd11: log_tab = 17'd49472;
      5'd12: log_tab = 17'd52911; 5'd13: log_tab = 17'd56229;
      5'd14: log_tab = 17'd59434; 5'd15: log_tab = 17'd62534;
      default: log_tab = 17'd65536;
    endcase
  endfunction

  // 2^(k/16) in Q16
  function automatic logic [17:0] exp_tab(input logic [4:0] k);
    case (k)
      5'd0: exp_tab = 18'd65536;   5'd1: exp_tab = 18'd68438;
      5'd2: exp_tab = 18'd71468;   5'd3: exp_tab = 18'd74632;
      5'd4: exp_tab = 18'd77936;   5'd5: exp_tab = 18'd81386;
      5'd6: exp_tab = 18'd84990;   5'd7: exp_tab = 18'd88752;
      5'd8: exp_tab = 18'd92682;   5'd9: exp_tab = 18'd96785;
      5'd10: exp_tab = 18'd101070; 5'd11: exp_tab = 18'd105545;
      5'd12: exp_tab = 18'd110218; 5'd13: exp_tab = 18'd115098;
      5'd14: exp_tab = 18'd120194; 5'd15: exp_tab = 18'd125515;
      default: exp_tab = 18'd131072;
    endcase
  endfunction

endpackage
`default_nettype wire

[rtl/tpb_lane.sv]
`default_nettype none
// One power lane: |n|^s via table log2, multiply, table exp2. Three stages.
module tpb_lane (
  input  wire logic        clk,
  input  wire logic [15:0] raw,
  input  wire logic [15:0] sharpness,
  output logic [16:0]      weight
);

  // stage 1: magnitude, leading one, log2 table interpolation
  logic [16:0] a;
  logic [3:0]  p;
  logic [15:0] m;
  logic [15:0] f;
  logic [16:0] l0;
  logic [16:0] l1;
  logic [28:0] lprod;
  logic [16:0] lf;
  logic [19:0] lneg_c;

  always_comb begin
    a = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    p = 4'd0;
    for (int b = 1; b < 16; b++) begin
      if (a[b]) p = 4'(b);
    end
    m = (a[15:0] << (4'd15 - p));
    if (a[16]) m = 16'h8000;
    f = {m[14:0], 1'b0};
    l0 = tpb_pkg::log_tab({1'b0, f[15:12]});
    l1 = tpb_pkg::log_tab({1'b0, f[15:12]} + 5'd1);
    lprod = (l1 - l0) * {5'd0, f[11:0]};
    lf = l0 + 17'(lprod >> 12);
    lneg_c = {(4'd15 - p), 16'd0} - {3'd0, lf};
  end

  logic [19:0] lneg;
  logic        zero_a1;
  logic        zero_s1;
  logic [15:0] s1;
  always_ff @(posedge clk) begin
    lneg <= lneg_c;
    zero_a1 <= (a == 17'd0);
    zero_s1 <= (sharpness == 16'd0);
    s1 <= sharpness;
  end

  // stage 2: exponent product
  logic [35:0] e_prod;
  logic [23:0] e;
  logic        zero_a2;
  logic        zero_s2;
  assign e_prod = lneg * s1;
  always_ff @(posedge clk) begin
    e <= e_prod[35:12];
    zero_a2 <= zero_a1;
    zero_s2 <= zero_s1;
  end

  // stage 3: exp2 table interpolation and shift
  logic [7:0]  q;
  logic [15:0] g;
  logic [16:0] h;
  logic [17:0] x0;
  logic [17:0] x1;
  logic [29:0] xprod;
  logic [17:0] xv;
  logic [17:0] w;
  logic [16:0] w_c;

  always_comb begin
    q = e[23:16];
    g = e[15:0];
    h = 17'h10000 - {1'b0, g};
    x0 = tpb_pkg::exp_tab({1'b0, h[15:12]});
    x1 = tpb_pkg::exp_tab({1'b0, h[15:12]} + 5'd1);
    xprod = (x1 - x0) * {6'd0, h[11:0]};
    xv = x0 + 18'(xprod >> 12);
    if (g == 16'd0) w = 18'h10000 >> q;
    else            w = xv >> (q + 8'd1);
    if (zero_s2)              w_c = 17'h10000;
    else if (zero_a2)         w_c = 17'd0;
    else if (q >= 8'd17)      w_c = 17'd0;
    else if (w > 18'h10000)   w_c = 17'h10000;
    else                      w_c = w[16:0];
  end

  always_ff @(posedge clk) begin
    weight <= w_c;
  end

endmodule
`default_nettype wire

[rtl/tpb_norm.sv]
`default_nettype none
// Merge: if enabled, divides each weight by the lane sum, radix-2, one bit per stage; else passes them through.
module tpb_norm (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        vin,
  input  wire logic        norm_en,
  input  wire logic [16:0] w_in [tpb_pkg::NLANES],
  output logic             vout,
  output logic [16:0]      w_out [tpb_pkg::NLANES]
);

  localparam int NS = 18;   // quotient bits needed, 0..65536 plus margin
  localparam int DW = 19;   // sum width
  localparam int NST = 33;  // dividend bits, one step each

  // staged pipeline: partial remainder, quotient, dividend bits left
  logic            v    [NST+1];
  logic            en   [NST+1];
  logic [DW-1:0]   den  [NST+1];
  logic [16:0]     raw  [NST+1][tpb_pkg::NLANES];
  logic [DW:0]     rem  [NST+1][tpb_pkg::NLANES];
  logic [NS-1:0]   quo  [NST+1][tpb_pkg::NLANES];
  logic [32:0]     dvd  [NST+1][tpb_pkg::NLANES];

  // stage 0 setup
  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else     v[0] <= vin;
    en[0] <= norm_en;
    den[0] <= DW'(w_in[0]) + DW'(w_in[1]) + DW'(w_in[2]);
    for (int k = 0; k < tpb_pkg::NLANES; k++) begin
      raw[0][k] <= w_in[k];
      rem[0][k] <= '0;
      quo[0][k] <= '0;
      dvd[0][k] <= {w_in[k], 16'd0};
    end
  end

  // one restoring step per stage, one dividend bit each
  for (genvar s = 0; s < NST; s++) begin : g_step
    always_ff @(posedge clk) begin
      logic [DW:0] t;
      if (rst) v[s+1] <= 1'b0;
      else     v[s+1] <= v[s];
      en[s+1] <= en[s];
      den[s+1] <= den[s];
      for (int k = 0; k < tpb_pkg::NLANES; k++) begin
        raw[s+1][k] <= raw[s][k];
        dvd[s+1][k] <= dvd[s][k] << 1;
        t = {rem[s][k][DW-1:0], dvd[s][k][32]};
        if (s < NST - NS) begin
          // leading dividend bits can never reach the quotient range
          rem[s+1][k] <= t;
          quo[s+1][k] <= quo[s][k];
        end else if (t >= {1'b0, den[s]}) begin
          rem[s+1][k] <= t - {1'b0, den[s]};
          quo[s+1][k] <= {quo[s][k][NS-2:0], 1'b1};
        end else begin
          rem[s+1][k] <= t;
          quo[s+1][k] <= {quo[s][k][NS-2:0], 1'b0};
        end
      end
    end
  end

  // output select and saturation
  always_ff @(posedge clk) begin
    if (rst) vout <= 1'b0;
    else     vout <= v[NST];
    for (int k = 0; k < tpb_pkg::NLANES; k++) begin
      if (!en[NST])                   w_out[k] <= raw[NST][k];
      else if (den[NST] == '0)        w_out[k] <= 17'(tpb_pkg::W_THIRD);
      else if (quo[NST][k] > NS'(tpb_pkg::W_ONE)) w_out[k] <= 17'(tpb_pkg::W_ONE);
      else                            w_out[k] <= quo[NST][k][16:0];
    end
  end

endmodule
`default_nettype wire

[rtl/triplanar_blend_weights_core.sv]
// Throughput: one normal per cycle; three power lanes and a one bit per stage
// divider pipeline in the merge stage set the latency.
// busy is always low; results cannot be stalled and leave on done for one cycle.
// Synchronous active-high reset clears the pipeline valids and loads
// sharpness 4096 and normalize_enable 1.
`default_nettype none
`include "assert_macros.svh"
module triplanar_blend_weights_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire tpb_pkg::in_t    in_data,
  output logic                 done,
  output tpb_pkg::out_t        out_data,
  input  wire logic            cfg_we,
  input  wire logic [0:0]      cfg_index,
  input  wire logic [15:0]     cfg_data
);

  // configuration registers
  logic [15:0] sharpness;
  logic        normalize_enable;
  always_ff @(posedge clk) begin
    if (rst) begin
      sharpness <= 16'd4096;
      normalize_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpb_pkg::REG_SHARPNESS: sharpness <= cfg_data;
        tpb_pkg::REG_NORMALIZE: normalize_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic        acc;
  assign acc = start && !busy;

  // valid line alongside the lanes
  logic [tpb_pkg::LANE_LAT-1:0] vline;
  always_ff @(posedge clk) begin
    if (rst) vline <= '0;
    else     vline <= {vline[tpb_pkg::LANE_LAT-2:0], acc};
  end

  logic [16:0] lw [tpb_pkg::NLANES];
  logic [15:0] raws [tpb_pkg::NLANES];
  assign raws[0] = in_data.normal_x;
  assign raws[1] = in_data.normal_y;
  assign raws[2] = in_data.normal_z;

  for (genvar k = 0; k < tpb_pkg::NLANES; k++) begin : g_lane
    tpb_lane u_lane (
      .clk(clk), .raw(raws[k]), .sharpness(sharpness), .weight(lw[k])
    );
  end

  logic        nv;
  logic [16:0] nw [tpb_pkg::NLANES];
  tpb_norm u_norm (
    .clk(clk), .rst(rst), .vin(vline[tpb_pkg::LANE_LAT-1]), .norm_en(normalize_enable),
    .w_in(lw), .vout(nv), .w_out(nw)
  );

  assign done = nv;
  assign out_data.weight_x = nw[0];
  assign out_data.weight_y = nw[1];
  assign out_data.weight_z = nw[2];

  `ASSERT_CLK_NR(a_rst_clear, clk, rst |=> !done, "done after reset")
  `ASSERT_CLK(a_sat, clk, rst, done |-> (out_data.weight_x <= 17'h10000), "x over 1.0")
  `ASSERT_CLK(a_busy, clk, rst, !busy, "busy raised")

endmodule
`default_nettype wire

[tb/tb_triplanar_blend_weights_core.sv]
`default_nettype none
module tb_triplanar_blend_weights_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 37;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  tpb_pkg::in_t in_data;
  logic done;
  tpb_pkg::out_t out_data;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [15:0] cfg_data;

  triplanar_blend_weights_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_data(in_data),
    .done(done), .out_data(out_data), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor copy of the registers
  logic [15:0] sharp_q412;
  logic norm_on;

  tpb_pkg::out_t weights_due[$];
  int mismatches;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // log2(1 + k/16) and 2^(k/16) in Q16
  function automatic int unsigned log2_seg(input int k);
    int unsigned t [17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
      42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
    return t[k];
  endfunction

  function automatic int unsigned exp2_seg(input int k);
    int unsigned t [17] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752,
      92682, 96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072};
    return t[k];
  endfunction

  // |n|^s in Q1.16 through a piecewise linear log2/exp2
  function automatic int unsigned raise_to_sharpness(input logic signed [15:0] n,
                                                     input logic [15:0] s);
    int unsigned mag, msb, mant, frac, idx, rem, lf, q, g, h, w;
    longint unsigned lneg, e;
    mag = (n < 0) ? 32'(-int'(n)) : 32'(n);
    if (s == 0) return 65536;
    if (mag == 0) return 0;
    msb = 15;
    while (msb > 0 && mag[msb] == 1'b0) msb--;
    mant = (mag << (15 - msb)) & 32'hFFFF;
    if (mag == 32768) mant = 32768;
    frac = ((mant - 32768) << 1) & 32'hFFFF;
    idx = frac >> 12;
    rem = frac & 4095;
    lf = log2_seg(idx) + (((log2_seg(idx + 1) - log2_seg(idx)) * rem) >> 12);
    lneg = longint'(15 - msb) * 65536 - lf;
    e = (lneg * s) >> 12;
    if ((e >> 16) >= 17) return 0;
    q = e >> 16;
    g = e & 64'hFFFF;
    if (g == 0) begin
      w = 65536 >> q;
    end else begin
      h = 65536 - g;
      idx = h >> 12;
      rem = h & 4095;
      w = (exp2_seg(idx) + (((exp2_seg(idx + 1) - exp2_seg(idx)) * rem) >> 12)) >> (q + 1);
    end
    return (w > 65536) ? 65536 : w;
  endfunction

  function automatic tpb_pkg::out_t blend_weights(input tpb_pkg::in_t nrm);
    int unsigned w [3];
    longint unsigned sum, v;
    tpb_pkg::out_t r;
    w[0] = raise_to_sharpness(nrm.normal_x, sharp_q412);
    w[1] = raise_to_sharpness(nrm.normal_y, sharp_q412);
    w[2] = raise_to_sharpness(nrm.normal_z, sharp_q412);
    if (norm_on) begin
      sum = longint'(w[0]) + w[1] + w[2];
      for (int k = 0; k < 3; k++) begin
        if (sum == 0) begin
          w[k] = tpb_pkg::W_THIRD;
        end else begin
          v = (longint'(w[k]) << 16) / sum;
          w[k] = (v > 65536) ? 65536 : 32'(v);
        end
      end
    end
    r.weight_x = w[0][16:0];
    r.weight_y = w[1][16:0];
    r.weight_z = w[2][16:0];
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    tpb_pkg::out_t want;
    if (!rst) begin
      cycles <= cycles + 1;
      if (done) begin
        if (weights_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data);
        end else begin
          want = weights_due.pop_front();
          if (want.weight_x !== out_data.weight_x || want.weight_y !== out_data.weight_y ||
              want.weight_z !== out_data.weight_z) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                       want.weight_x, want.weight_y, want.weight_z,
                       out_data.weight_x, out_data.weight_y, out_data.weight_z);
          end
        end
      end
    end
  end

  // timeout watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL triplanar_blend_weights_core");
      $finish;
    end
  end

  // start stays high across back-to-back transfers; drain drops it
  task automatic send_normal(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z, input bit use_gap);
    tpb_pkg::in_t nrm;
    int gap;
    gap = use_gap ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    nrm.normal_x = x;
    nrm.normal_y = y;
    nrm.normal_z = z;
    in_data <= nrm;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    weights_due.push_back(blend_weights(nrm));
    @(negedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (weights_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == tpb_pkg::REG_SHARPNESS) sharp_q412 = val;
    else norm_on = val[0];
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_comp;
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h0000;
      2: return 16'h7FFF;
      3: return 16'(16'sd1 << $urandom_range(0, 14));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed;
    send_normal(16'sh7FFF, 0, 0, 0);
    send_normal(16'sh8000, 16'sh8000, 16'sh8000, 0);
    send_normal(0, 0, 0, 0);
    send_normal(1, -1, 16'sh4000, 0);
    send_normal(16'shFFFF, 16'sh5A82, 16'shA57E, 0);
    send_normal(16'sh5555, 16'shAAAA, 16'sh0001, 0);
    drain();
  endtask

  // sweep sharpness including zero and full scale, with normalization on and off
  task automatic test_settings;
    logic [15:0] sharps [6] = '{16'd0, 16'd1, 16'd4096, 16'd8192, 16'd40000, 16'hFFFF};
    foreach (sharps[i]) begin
      for (int nm = 0; nm < 2; nm++) begin
        write_reg(tpb_pkg::REG_SHARPNESS, sharps[i]);
        write_reg(tpb_pkg::REG_NORMALIZE, nm[0] ? 16'hFFFF : 16'hFFFE);
        send_normal(0, 0, 0, 0);
        send_normal(16'sh8000, 16'sh7FFF, 0, 0);
        send_normal(16'sh1234, -16'sh2345, 16'sh3456, 0);
        drain();
      end
    end
  endtask

  task automatic test_random;
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(tpb_pkg::REG_SHARPNESS,
                (ph % 3 == 0) ? 16'($urandom) : 16'($urandom_range(0, 16384)));
      write_reg(tpb_pkg::REG_NORMALIZE, 16'($urandom));
      for (int i = 0; i < 70; i++)
        send_normal(rand_comp(), rand_comp(), rand_comp(), (ph % 4) != 1);
      drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    cycles = 0;
    sharp_q412 = 16'd4096;
    norm_on = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_settings();
    test_random();
    if (mismatches == 0 && weights_due.size() == 0) begin
      $display("PASS triplanar_blend_weights_core");
    end else begin
      $display("FAIL triplanar_blend_weights_core");
    end
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/tpb_pkg.sv
rtl/tpb_lane.sv
rtl/tpb_norm.sv
rtl/triplanar_blend_weights_core.sv
tb/tb_triplanar_blend_weights_core.sv
